@@ src/vector3_normalize_unit_macros.svh @@
// Assertion macros shared by the normalizer RTL.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VNU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VNU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector3_normalize_unit: next-cycle check failed");

`endif

@@ src/vnu_pkg.sv @@
package vnu_pkg;

    localparam int NUM_COMP    = 3;
    localparam int ROOT_W      = 16;
    localparam int FIRST_ROOT  = 3;
    localparam int DIV_SETUP   = FIRST_ROOT + ROOT_W;
    localparam int FIRST_DIV   = DIV_SETUP + 1;
    localparam int LAST_STAGE  = FIRST_DIV + ROOT_W;
    localparam int NUM_STAGES  = LAST_STAGE + 1;

    localparam logic [15:0] POS_LIMIT = 16'h7FFF;
    localparam logic [15:0] NEG_LIMIT = 16'h8000;

    // One record travels down the pipeline; each stage fills in its part.
    typedef struct packed {
        logic [2:0][15:0] comp;
        logic [14:0]      target;
        logic [2:0]       neg;
        logic [2:0][31:0] sq;
        logic [2:0][30:0] num;
        logic [31:0]      rad;
        logic [17:0]      srem;
        logic [15:0]      root;
        logic             zero;
        logic [2:0]       ovf;
        logic [2:0][15:0] drem;
        logic [2:0][15:0] quo;
        logic [2:0][15:0] res;
    } stage_t;

endpackage

@@ src/vector3_normalize_unit.sv @@
// Pipeline: an accepted request passes the load, multiply, sum, root, divide-setup, divide and output stages.
// Throughput: one request per cycle while out_stall is low; the 16 root stages and 16 divide
// stages each resolve one bit per register stage, so every stage takes a new request each cycle.
// Reset: rst_n clears all stage valid bits asynchronously; the data path is not reset.
`include "vector3_normalize_unit_macros.svh"

module vector3_normalize_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] vec_x,
    input  logic [15:0] vec_y,
    input  logic [15:0] vec_z,
    input  logic [14:0] target_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_x,
    output logic [15:0] out_y,
    output logic [15:0] out_z,
    output logic        was_zero
);

    localparam int N    = vnu_pkg::NUM_STAGES;
    localparam int LAST = vnu_pkg::LAST_STAGE;

    vnu_pkg::stage_t stage_reg  [N];
    vnu_pkg::stage_t stage_next [N];
    logic [N-1:0]    valid_reg;
    logic [N-1:0]    stage_ready;

    // Each stage may load when it is empty or its content moves on this cycle.
    // This lets bubbles close up while the output side is stalled.
    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || !out_stall;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = valid_reg[LAST];
    assign out_x     = stage_reg[LAST].res[0];
    assign out_y     = stage_reg[LAST].res[1];
    assign out_z     = stage_reg[LAST].res[2];
    assign was_zero  = stage_reg[LAST].zero;

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic prev_valid;

        if (s == 0)
        begin : g_in
            assign prev_valid = in_valid;
        end
        else
        begin : g_mid
            assign prev_valid = valid_reg[s-1];
        end

        if (s == 0)
        begin : g_load
            // Capture the request as it stands.
            always_comb
            begin
                stage_next[s]         = '0;
                stage_next[s].comp[0] = vec_x;
                stage_next[s].comp[1] = vec_y;
                stage_next[s].comp[2] = vec_z;
                stage_next[s].target  = target_length;
            end
        end
        else if (s == 1)
        begin : g_mult
            // Magnitudes, their squares and the scaled numerators.
            always_comb
            begin
                logic [15:0] mag;
                stage_next[s] = stage_reg[s-1];
                for (int c = 0; c < vnu_pkg::NUM_COMP; c++)
                begin
                    mag = stage_reg[s-1].comp[c][15] ?
                          16'(~stage_reg[s-1].comp[c] + 16'd1) : stage_reg[s-1].comp[c];
                    stage_next[s].neg[c] = stage_reg[s-1].comp[c][15];
                    stage_next[s].sq[c]  = 32'(mag) * 32'(mag);
                    stage_next[s].num[c] = 31'({15'd0, mag} * {16'd0, stage_reg[s-1].target});
                end
            end
        end
        else if (s == 2)
        begin : g_sum
            // The sum of three squares is below 2^32, so no carry is lost.
            always_comb
            begin
                logic [31:0] sum;
                sum = stage_reg[s-1].sq[0] + stage_reg[s-1].sq[1] + stage_reg[s-1].sq[2];
                stage_next[s]      = stage_reg[s-1];
                stage_next[s].rad  = sum;
                stage_next[s].zero = (sum == 32'd0);
                stage_next[s].srem = '0;
                stage_next[s].root = '0;
            end
        end
        else if (s < vnu_pkg::DIV_SETUP)
        begin : g_root
            // One digit-method root bit: bring down two radicand bits, try 4r+1.
            localparam int K = vnu_pkg::ROOT_W - 1 - (s - vnu_pkg::FIRST_ROOT);
            always_comb
            begin
                logic [19:0] cur;
                logic [19:0] trial;
                cur   = {stage_reg[s-1].srem, stage_reg[s-1].rad[2*K+1 -: 2]};
                trial = {2'b00, stage_reg[s-1].root, 2'b01};
                stage_next[s] = stage_reg[s-1];
                if (cur >= trial)
                begin
                    stage_next[s].srem = 18'(cur - trial);
                    stage_next[s].root = {stage_reg[s-1].root[14:0], 1'b1};
                end
                else
                begin
                    stage_next[s].srem = 18'(cur);
                    stage_next[s].root = {stage_reg[s-1].root[14:0], 1'b0};
                end
            end
        end
        else if (s == vnu_pkg::DIV_SETUP)
        begin : g_dsetup
            // When the upper numerator bits reach the length, the quotient is at
            // least 2^16 and saturates; otherwise sixteen quotient bits suffice.
            always_comb
            begin
                stage_next[s] = stage_reg[s-1];
                for (int c = 0; c < vnu_pkg::NUM_COMP; c++)
                begin
                    stage_next[s].ovf[c]  = {1'b0, stage_reg[s-1].num[c][30:16]} >=
                                            stage_reg[s-1].root;
                    stage_next[s].drem[c] = {1'b0, stage_reg[s-1].num[c][30:16]};
                    stage_next[s].quo[c]  = '0;
                end
            end
        end
        else if (s < LAST)
        begin : g_div
            // One restoring-division bit for each component.
            localparam int J = vnu_pkg::ROOT_W - 1 - (s - vnu_pkg::FIRST_DIV);
            always_comb
            begin
                logic [16:0] cur;
                stage_next[s] = stage_reg[s-1];
                for (int c = 0; c < vnu_pkg::NUM_COMP; c++)
                begin
                    cur = {stage_reg[s-1].drem[c], stage_reg[s-1].num[c][J]};
                    if (cur >= {1'b0, stage_reg[s-1].root})
                    begin
                        stage_next[s].drem[c] = 16'(cur - {1'b0, stage_reg[s-1].root});
                        stage_next[s].quo[c]  = {stage_reg[s-1].quo[c][14:0], 1'b1};
                    end
                    else
                    begin
                        stage_next[s].drem[c] = 16'(cur);
                        stage_next[s].quo[c]  = {stage_reg[s-1].quo[c][14:0], 1'b0};
                    end
                end
            end
        end
        else
        begin : g_out
            // Sign, saturate, and force zeros for a zero vector.
            always_comb
            begin
                logic [15:0] q;
                stage_next[s] = stage_reg[s-1];
                for (int c = 0; c < vnu_pkg::NUM_COMP; c++)
                begin
                    q = stage_reg[s-1].quo[c];
                    if (stage_reg[s-1].zero)
                    begin
                        stage_next[s].res[c] = '0;
                    end
                    else if (stage_reg[s-1].neg[c])
                    begin
                        if (stage_reg[s-1].ovf[c] || q > vnu_pkg::NEG_LIMIT)
                        begin
                            stage_next[s].res[c] = vnu_pkg::NEG_LIMIT;
                        end
                        else
                        begin
                            stage_next[s].res[c] = 16'(~q + 16'd1);
                        end
                    end
                    else if (stage_reg[s-1].ovf[c] || q > vnu_pkg::POS_LIMIT)
                    begin
                        stage_next[s].res[c] = vnu_pkg::POS_LIMIT;
                    end
                    else
                    begin
                        stage_next[s].res[c] = q;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && prev_valid)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    `VNU_ASSERT_SAME(a_stall_only_when_full, in_stall, valid_reg[0])
    `VNU_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_reg[0])
    `VNU_ASSERT_SAME(a_zero_gives_zeros, out_valid && was_zero,
                     out_x == 16'd0 && out_y == 16'd0 && out_z == 16'd0)
    `VNU_ASSERT_NEXT(a_result_held, out_valid && out_stall,
                     out_valid && $stable(out_x) && $stable(was_zero))

endmodule
